// ----- rtl/core/hpvp_pkg.sv -----
// Shared types and constants for the head-pose view-projection block.
// Control word layout, operand and write-back codes, fixed-point widths.
// No dependencies.
`default_nettype none

package hpvp_pkg;

	// Fixed-point widths
	localparam int Q_W    = 16;   // Q2.14 quaternion components, Q4.12 scales
	localparam int REL_W  = 20;   // relative quaternion, Q.14
	localparam int H_W    = 40;   // rotation entries, Q.28
	localparam int HLO_W  = 20;   // low part of a rotation entry
	localparam int OPD_W  = 21;   // multiplier operand
	localparam int PROD_W = 42;   // multiplier product
	localparam int ACC_W  = 58;   // accumulator
	localparam int OUT_W  = 24;   // Q8.16 result entries
	localparam int OUT_N  = 12;
	localparam int ROT_N  = 9;
	localparam int QN     = 4;
	localparam int IDX_W  = 4;
	localparam int PC_W   = 6;

	localparam int REL_SHIFT   = 14;
	localparam int HI_SHIFT    = 20;
	localparam int SCALED_SHIFT = 24;
	localparam int NEG_SHIFT   = 12;

	localparam logic signed [Q_W-1:0] Q14_ONE = 16'sd16384;
	localparam logic signed [Q_W-1:0] Q_MAX   = 16'sd32767;
	localparam logic signed [Q_W-1:0] Q_MIN   = -16'sd32768;

	localparam logic signed [ACC_W-1:0] ACC_HALF12 = ACC_W'(2**11);
	localparam logic signed [ACC_W-1:0] ACC_HALF14 = ACC_W'(2**13);
	localparam logic signed [ACC_W-1:0] ACC_HALF24 = ACC_W'(2**23);
	localparam logic signed [ACC_W-1:0] ACC_ONE28  = ACC_W'(2**28);
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(2**(OUT_W-1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(2**(OUT_W-1));

	// Configuration registers
	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_X_SCALE     = 2'd0;
	localparam logic [1:0] REG_Y_SCALE     = 2'd1;
	localparam logic [1:0] REG_DEPTH_SCALE = 2'd2;
	localparam logic signed [Q_W-1:0] X_SCALE_RST     = 16'sd5443;
	localparam logic signed [Q_W-1:0] Y_SCALE_RST     = 16'sd9650;
	localparam logic signed [Q_W-1:0] DEPTH_SCALE_RST = -16'sd4104;

	typedef enum logic [4:0] {
		S_P0, S_P1, S_P2, S_P3,
		S_O0, S_O1, S_O2, S_O3,
		S_R0, S_R1, S_R2, S_R3,
		S_SX, S_SY, S_SZ, S_ONE,
		S_HHI, S_HLO
	} src_t;

	typedef enum logic [2:0] {
		AO_NOP, AO_LOAD_ADD, AO_LOAD_SUB, AO_ADD, AO_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		K_ZERO, K_HALF12, K_HALF14, K_HALF24, K_ONE28
	} konst_t;

	typedef enum logic [1:0] {
		SH_0, SH_1, SH_20
	} shift_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_REL, WB_ROT, WB_OUT24, WB_OUT12
	} wb_t;

	typedef enum logic {
		SQ_NEXT, SQ_PUBLISH
	} seq_t;

	typedef enum logic {
		SEQ_IDLE, SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		src_t             a_sel;
		src_t             b_sel;
		logic [IDX_W-1:0] hidx;
		acc_op_t          acc_op;
		konst_t           konst;
		shift_t           shift;
		wb_t              wb;
		logic [IDX_W-1:0] dst;
		seq_t             seq;
	} ucode_t;

	typedef struct packed {
		acc_op_t          acc_op;
		konst_t           konst;
		shift_t           shift;
		wb_t              wb;
		logic [IDX_W-1:0] dst;
	} stage_ctrl_t;

	localparam ucode_t UC_NOP = '{
		a_sel: S_ONE, b_sel: S_ONE, hidx: '0, acc_op: AO_NOP, konst: K_ZERO,
		shift: SH_0, wb: WB_NONE, dst: '0, seq: SQ_NEXT
	};

endpackage

`default_nettype wire

// ----- rtl/core/head_pose_view_projection.sv -----
// Head-pose view-projection: top level with the configuration port and the stream ports.
// Depends on hpvp_pkg, hpvp_sequencer and hpvp_datapath.
//
// Use: each input transaction on s_* carries one raw NWU head-pose quaternion (Q2.14)
// with a valid flag and a recenter flag. The block remaps it to EUS, optionally stores
// its conjugate as the new origin, forms origin * pose, expands it to a rotation,
// transposes it into the view and scales it by the three perspective registers. One
// output transaction on m_* then carries the twelve varying projection-view entries
// in Q8.16, saturated.
// Operation: a 61-step microprogram drives one shared 21x21 multiplier and one
// accumulator, one product per step; the result is loaded into the output register
// on the final step, and the next input is taken in the cycle after that, so the
// block takes no new pose until the last one is published.
// Stall: the result sits in an output register; while m_tready stays low a finished
// item waits on the last step, and s_tready stays low until the slot frees.
// Reset: the scale registers return to their defaults, the origin to the identity,
// and the block is idle with s_tready high.
// Configuration: APB writes at byte addresses 0, 4, 8; the user writes only while idle, the block does not enforce it.
`default_nettype none

module head_pose_view_projection import hpvp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_AW-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// pose input
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [4*Q_W-1:0]         s_tdata,   // raw_x, raw_y, raw_z, raw_w
	input  logic [1:0]               s_tuser,   // pose_valid, recenter_now
	// projection-view output
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_N*OUT_W-1:0]   m_tdata    // pv_c0_r0 .. pv_c0_r3, pv_c1_r0 .. pv_c2_r3
);

	logic signed [Q_W-1:0] x_scale_q, y_scale_q, depth_scale_q;
	logic [1:0]            reg_idx;
	logic                  cfg_wr;

	logic                  in_accept, busy, publish, out_free;
	ucode_t                uc;
	logic [OUT_N*OUT_W-1:0] pv_work;

	logic                  m_tvalid_q;
	logic [OUT_N*OUT_W-1:0] m_tdata_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q     <= X_SCALE_RST;
			y_scale_q     <= Y_SCALE_RST;
			depth_scale_q <= DEPTH_SCALE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_X_SCALE:     x_scale_q     <= pwdata[Q_W-1:0];
				REG_Y_SCALE:     y_scale_q     <= pwdata[Q_W-1:0];
				REG_DEPTH_SCALE: depth_scale_q <= pwdata[Q_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_X_SCALE:     prdata = 32'(x_scale_q);
			REG_Y_SCALE:     prdata = 32'(y_scale_q);
			REG_DEPTH_SCALE: prdata = 32'(depth_scale_q);
			default:         prdata = '0;
		endcase
	end

	assign s_tready  = !busy;
	assign in_accept = s_tvalid & s_tready;
	assign out_free  = !m_tvalid_q | m_tready;

	hpvp_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.out_free (out_free),
		.busy     (busy),
		.publish  (publish),
		.uc       (uc)
	);

	hpvp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept),
		.raw_x        (s_tdata[Q_W-1:0]),
		.raw_y        (s_tdata[2*Q_W-1:Q_W]),
		.raw_z        (s_tdata[3*Q_W-1:2*Q_W]),
		.raw_w        (s_tdata[4*Q_W-1:3*Q_W]),
		.pose_valid   (s_tuser[0]),
		.recenter_now (s_tuser[1]),
		.x_scale      (x_scale_q),
		.y_scale      (y_scale_q),
		.depth_scale  (depth_scale_q),
		.uc           (uc),
		.pv_work      (pv_work)
	);

	// Output register: load on publish, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (publish)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (publish)
			m_tdata_q <= pv_work;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/hpvp_ucode_rom.sv -----
// Control store of the head-pose sequencer: one control word per step.
// Steps 0-15 Hamilton product, 16-33 rotation entries, 34-57 projection.
// Depends on hpvp_pkg.
`default_nettype none

module hpvp_ucode_rom import hpvp_pkg::*; (
	input  logic [PC_W-1:0] pc,
	output ucode_t          uc
);

	function automatic ucode_t mk(src_t a, src_t b, logic [IDX_W-1:0] hidx, acc_op_t op,
		konst_t k, shift_t sh, wb_t wb, logic [IDX_W-1:0] dst);
		ucode_t u;
		u        = UC_NOP;
		u.a_sel  = a;
		u.b_sel  = b;
		u.hidx   = hidx;
		u.acc_op = op;
		u.konst  = k;
		u.shift  = sh;
		u.wb     = wb;
		u.dst    = dst;
		return u;
	endfunction

	always_comb begin
		uc = UC_NOP;
		case (pc)
			// rel = origin * pose, biased for round half up
			6'd0:  uc = mk(S_O3, S_P0, 4'd0, AO_LOAD_ADD, K_HALF14, SH_0, WB_NONE, 4'd0);
			6'd1:  uc = mk(S_O0, S_P3, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd2:  uc = mk(S_O1, S_P2, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd3:  uc = mk(S_O2, S_P1, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_REL,  4'd0);
			6'd4:  uc = mk(S_O3, S_P1, 4'd0, AO_LOAD_ADD, K_HALF14, SH_0, WB_NONE, 4'd0);
			6'd5:  uc = mk(S_O0, S_P2, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd6:  uc = mk(S_O1, S_P3, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd7:  uc = mk(S_O2, S_P0, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_REL,  4'd1);
			6'd8:  uc = mk(S_O3, S_P2, 4'd0, AO_LOAD_ADD, K_HALF14, SH_0, WB_NONE, 4'd0);
			6'd9:  uc = mk(S_O0, S_P1, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd10: uc = mk(S_O1, S_P0, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd11: uc = mk(S_O2, S_P3, 4'd0, AO_ADD,      K_ZERO,   SH_0, WB_REL,  4'd2);
			6'd12: uc = mk(S_O3, S_P3, 4'd0, AO_LOAD_ADD, K_HALF14, SH_0, WB_NONE, 4'd0);
			6'd13: uc = mk(S_O0, S_P0, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd14: uc = mk(S_O1, S_P1, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_NONE, 4'd0);
			6'd15: uc = mk(S_O2, S_P2, 4'd0, AO_SUB,      K_ZERO,   SH_0, WB_REL,  4'd3);
			// rotation entries; diagonal first so that w is ready by step 23
			6'd16: uc = mk(S_R1, S_R1, 4'd0, AO_LOAD_SUB, K_ONE28,  SH_1, WB_NONE, 4'd0);
			6'd17: uc = mk(S_R2, S_R2, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd0);
			6'd18: uc = mk(S_R0, S_R0, 4'd0, AO_LOAD_SUB, K_ONE28,  SH_1, WB_NONE, 4'd0);
			6'd19: uc = mk(S_R2, S_R2, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd4);
			6'd20: uc = mk(S_R0, S_R0, 4'd0, AO_LOAD_SUB, K_ONE28,  SH_1, WB_NONE, 4'd0);
			6'd21: uc = mk(S_R1, S_R1, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd8);
			6'd22: uc = mk(S_R0, S_R1, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd23: uc = mk(S_R2, S_R3, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd1);
			6'd24: uc = mk(S_R0, S_R2, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd25: uc = mk(S_R1, S_R3, 4'd0, AO_ADD,      K_ZERO,   SH_1, WB_ROT,  4'd2);
			6'd26: uc = mk(S_R0, S_R1, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd27: uc = mk(S_R2, S_R3, 4'd0, AO_ADD,      K_ZERO,   SH_1, WB_ROT,  4'd3);
			6'd28: uc = mk(S_R1, S_R2, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd29: uc = mk(S_R0, S_R3, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd5);
			6'd30: uc = mk(S_R0, S_R2, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd31: uc = mk(S_R1, S_R3, 4'd0, AO_SUB,      K_ZERO,   SH_1, WB_ROT,  4'd6);
			6'd32: uc = mk(S_R1, S_R2, 4'd0, AO_LOAD_ADD, K_ZERO,   SH_1, WB_NONE, 4'd0);
			6'd33: uc = mk(S_R0, S_R3, 4'd0, AO_ADD,      K_ZERO,   SH_1, WB_ROT,  4'd7);
			// column 0: scale times entry, high part then low part, then the negated depth entry
			6'd34: uc = mk(S_HHI, S_SX, 4'd0, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd35: uc = mk(S_HLO, S_SX, 4'd0, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd0);
			6'd36: uc = mk(S_HHI, S_SY, 4'd1, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd37: uc = mk(S_HLO, S_SY, 4'd1, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd1);
			6'd38: uc = mk(S_HHI, S_SZ, 4'd2, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd39: uc = mk(S_HLO, S_SZ, 4'd2, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd2);
			6'd40: uc = mk(S_HHI, S_ONE, 4'd2, AO_LOAD_SUB, K_HALF12, SH_20, WB_NONE, 4'd0);
			6'd41: uc = mk(S_HLO, S_ONE, 4'd2, AO_SUB,      K_ZERO,   SH_0,  WB_OUT12, 4'd3);
			// column 1
			6'd42: uc = mk(S_HHI, S_SX, 4'd3, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd43: uc = mk(S_HLO, S_SX, 4'd3, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd4);
			6'd44: uc = mk(S_HHI, S_SY, 4'd4, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd45: uc = mk(S_HLO, S_SY, 4'd4, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd5);
			6'd46: uc = mk(S_HHI, S_SZ, 4'd5, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd47: uc = mk(S_HLO, S_SZ, 4'd5, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd6);
			6'd48: uc = mk(S_HHI, S_ONE, 4'd5, AO_LOAD_SUB, K_HALF12, SH_20, WB_NONE, 4'd0);
			6'd49: uc = mk(S_HLO, S_ONE, 4'd5, AO_SUB,      K_ZERO,   SH_0,  WB_OUT12, 4'd7);
			// column 2
			6'd50: uc = mk(S_HHI, S_SX, 4'd6, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd51: uc = mk(S_HLO, S_SX, 4'd6, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd8);
			6'd52: uc = mk(S_HHI, S_SY, 4'd7, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd53: uc = mk(S_HLO, S_SY, 4'd7, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd9);
			6'd54: uc = mk(S_HHI, S_SZ, 4'd8, AO_LOAD_ADD, K_HALF24, SH_20, WB_NONE, 4'd0);
			6'd55: uc = mk(S_HLO, S_SZ, 4'd8, AO_ADD,      K_ZERO,   SH_0,  WB_OUT24, 4'd10);
			6'd56: uc = mk(S_HHI, S_ONE, 4'd8, AO_LOAD_SUB, K_HALF12, SH_20, WB_NONE, 4'd0);
			6'd57: uc = mk(S_HLO, S_ONE, 4'd8, AO_SUB,      K_ZERO,   SH_0,  WB_OUT12, 4'd11);
			// steps 58 and 59 drain the write-back; hold here until the output is free
			6'd60: uc.seq = SQ_PUBLISH;
			default: uc = UC_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/hpvp_sequencer.sv -----
// Step counter and control for the head-pose microprogram.
// Issues one control word per cycle while running; waits on the output slot at the end.
// Depends on hpvp_pkg and hpvp_ucode_rom.
`default_nettype none

module hpvp_sequencer import hpvp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   out_free,
	output logic   busy,
	output logic   publish,
	output ucode_t uc
);

	seq_state_t      state_q, state_d;
	logic [PC_W-1:0] pc_q;
	ucode_t          rom_word;
	logic            at_end;

	hpvp_ucode_rom u_rom (
		.pc (pc_q),
		.uc (rom_word)
	);

	assign at_end = (rom_word.seq == SQ_PUBLISH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start)
					state_d = SEQ_RUN;
			end
			SEQ_RUN: begin
				if (at_end && out_free)
					state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b0;
		publish = 1'b0;
		uc      = UC_NOP;
		case (state_q)
			SEQ_RUN: begin
				busy    = 1'b1;
				publish = at_end && out_free;
				uc      = rom_word;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			// hold on the final step until the next start
			if (start)
				pc_q <= '0;
			else if (state_q == SEQ_RUN && !at_end)
				pc_q <= pc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hpvp_datapath.sv -----
// Datapath of the head-pose block: pose and origin registers, shared multiplier,
// accumulator and write-back into the relative quaternion, rotation and result registers.
// Depends on hpvp_pkg.
`default_nettype none

module hpvp_datapath import hpvp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic signed [Q_W-1:0]      raw_x,
	input  logic signed [Q_W-1:0]      raw_y,
	input  logic signed [Q_W-1:0]      raw_z,
	input  logic signed [Q_W-1:0]      raw_w,
	input  logic                       pose_valid,
	input  logic                       recenter_now,
	input  logic signed [Q_W-1:0]      x_scale,
	input  logic signed [Q_W-1:0]      y_scale,
	input  logic signed [Q_W-1:0]      depth_scale,
	input  ucode_t                     uc,
	output logic [OUT_N*OUT_W-1:0]     pv_work
);

	logic signed [Q_W-1:0]    p_next [QN];
	logic signed [Q_W-1:0]    p_q    [QN];
	logic signed [Q_W-1:0]    o_q    [QN];
	logic signed [REL_W-1:0]  r_q    [QN];
	logic signed [H_W-1:0]    h_q    [ROT_N];
	logic [OUT_W-1:0]         work_q [OUT_N];

	logic signed [H_W-1:0]    h_sel;
	logic signed [OPD_W-1:0]  opnd   [2];
	logic signed [PROD_W-1:0] prod_s1;
	stage_ctrl_t              ctrl_s1, ctrl_s2;

	logic signed [ACC_W-1:0]  acc_q, acc_next, prod_ext, term, kval, base;
	logic                     do_sub, do_load;
	logic signed [ACC_W-1:0]  shifted;
	logic [OUT_W-1:0]         sat_val;

	function automatic logic signed [Q_W-1:0] neg_sat(logic signed [Q_W-1:0] v);
		return (v == Q_MIN) ? Q_MAX : -v;
	endfunction

	// NWU to EUS remap; an invalid pose becomes the identity
	always_comb begin
		if (pose_valid) begin
			p_next[0] = neg_sat(raw_y);
			p_next[1] = raw_z;
			p_next[2] = neg_sat(raw_x);
			p_next[3] = raw_w;
		end else begin
			p_next[0] = '0;
			p_next[1] = '0;
			p_next[2] = '0;
			p_next[3] = Q14_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			for (int i = 0; i < QN; i++)
				p_q[i] <= p_next[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q[0] <= '0;
			o_q[1] <= '0;
			o_q[2] <= '0;
			o_q[3] <= Q14_ONE;
		end else if (load && recenter_now) begin
			o_q[0] <= neg_sat(p_next[0]);
			o_q[1] <= neg_sat(p_next[1]);
			o_q[2] <= neg_sat(p_next[2]);
			o_q[3] <= p_next[3];
		end
	end

	// Operand selection for both multiplier ports
	always_comb begin
		src_t sel;
		h_sel = h_q[uc.hidx];
		for (int i = 0; i < 2; i++) begin
			sel = (i == 0) ? uc.a_sel : uc.b_sel;
			case (sel)
				S_P0:    opnd[i] = OPD_W'(p_q[0]);
				S_P1:    opnd[i] = OPD_W'(p_q[1]);
				S_P2:    opnd[i] = OPD_W'(p_q[2]);
				S_P3:    opnd[i] = OPD_W'(p_q[3]);
				S_O0:    opnd[i] = OPD_W'(o_q[0]);
				S_O1:    opnd[i] = OPD_W'(o_q[1]);
				S_O2:    opnd[i] = OPD_W'(o_q[2]);
				S_O3:    opnd[i] = OPD_W'(o_q[3]);
				S_R0:    opnd[i] = OPD_W'(r_q[0]);
				S_R1:    opnd[i] = OPD_W'(r_q[1]);
				S_R2:    opnd[i] = OPD_W'(r_q[2]);
				S_R3:    opnd[i] = OPD_W'(r_q[3]);
				S_SX:    opnd[i] = OPD_W'(x_scale);
				S_SY:    opnd[i] = OPD_W'(y_scale);
				S_SZ:    opnd[i] = OPD_W'(depth_scale);
				S_ONE:   opnd[i] = OPD_W'(1);
				// high part keeps the sign of the entry
				S_HHI:   opnd[i] = OPD_W'(signed'(h_sel[H_W-1:HLO_W]));
				S_HLO:   opnd[i] = signed'({1'b0, h_sel[HLO_W-1:0]});
				default: opnd[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opnd[0] * opnd[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1.acc_op <= uc.acc_op;
			ctrl_s1.konst  <= uc.konst;
			ctrl_s1.shift  <= uc.shift;
			ctrl_s1.wb     <= uc.wb;
			ctrl_s1.dst    <= uc.dst;
			ctrl_s2        <= ctrl_s1;
		end
	end

	// Accumulate: a load step starts from the rounding bias, the constant one or zero
	always_comb begin
		prod_ext = ACC_W'(prod_s1);
		case (ctrl_s1.shift)
			SH_1:    term = prod_ext <<< 1;
			SH_20:   term = prod_ext <<< HI_SHIFT;
			default: term = prod_ext;
		endcase
		case (ctrl_s1.konst)
			K_HALF12: kval = ACC_HALF12;
			K_HALF14: kval = ACC_HALF14;
			K_HALF24: kval = ACC_HALF24;
			K_ONE28:  kval = ACC_ONE28;
			default:  kval = '0;
		endcase
		do_load = 1'b0;
		do_sub  = 1'b0;
		case (ctrl_s1.acc_op)
			AO_LOAD_ADD: do_load = 1'b1;
			AO_LOAD_SUB: begin
				do_load = 1'b1;
				do_sub  = 1'b1;
			end
			AO_SUB:  do_sub = 1'b1;
			default: ;
		endcase
		base     = do_load ? kval : acc_q;
		acc_next = do_sub ? (base - term) : (base + term);
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.acc_op != AO_NOP)
			acc_q <= acc_next;
	end

	always_comb begin
		shifted = (ctrl_s2.wb == WB_OUT24) ? (acc_q >>> SCALED_SHIFT) : (acc_q >>> NEG_SHIFT);
		if (shifted > SAT_HI)
			sat_val = SAT_HI[OUT_W-1:0];
		else if (shifted < SAT_LO)
			sat_val = SAT_LO[OUT_W-1:0];
		else
			sat_val = shifted[OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (ctrl_s2.wb)
			WB_REL:   r_q[ctrl_s2.dst[1:0]] <= acc_q[REL_SHIFT +: REL_W];
			WB_ROT:   h_q[ctrl_s2.dst]      <= acc_q[H_W-1:0];
			WB_OUT24: work_q[ctrl_s2.dst]   <= sat_val;
			WB_OUT12: work_q[ctrl_s2.dst]   <= sat_val;
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < OUT_N; i++)
			pv_work[i*OUT_W +: OUT_W] = work_q[i];
	end

endmodule

`default_nettype wire

// ----- test/head_pose_view_projection_tb.sv -----
// Self-checking testbench for head_pose_view_projection: drives poses on the input stream and
// scale writes over the register port, and checks every projection-view result.
// Depends on hpvp_pkg and the block's RTL; expectations come from a predictor kept in this file.
`timescale 1ns / 100ps

module head_pose_view_projection_tb;
	import hpvp_pkg::*;

	localparam int PV_W = OUT_N*OUT_W;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 200;

	// pose as it travels on s_tdata / s_tuser
	typedef struct packed {
		logic signed [Q_W-1:0] raw_x;
		logic signed [Q_W-1:0] raw_y;
		logic signed [Q_W-1:0] raw_z;
		logic signed [Q_W-1:0] raw_w;
		logic                  pose_valid;
		logic                  recentre;
		logic                  typed;
	} pose_row_t;

	// identity rotation under the reset scales, packed c2_r3 .. c0_r0
	localparam logic [PV_W-1:0] IDENTITY_PV = {
		-24'sd65536, -24'sd65664, 24'sd0, 24'sd0,
		24'sd0, 24'sd0, 24'sd154400, 24'sd0,
		24'sd0, 24'sd0, 24'sd0, 24'sd87088
	};

	localparam int DIRECTED_N = 21;
	localparam pose_row_t DIRECTED_POSES [DIRECTED_N] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1},           // invalid: identity
		'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b0, 1'b1},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b1, 1'b1},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0, 1'b0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 1'b0},
		// most negative everywhere: remap and conjugate both clip
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1, 1'b0},
		'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b1, 1'b0, 1'b0},
		'{16'sd5000, -16'sd7000, 16'sd9000, 16'sd12000, 1'b1, 1'b1, 1'b0},
		'{16'sd5000, -16'sd7000, 16'sd9000, 16'sd12000, 1'b1, 1'b0, 1'b0},
		'{-16'sd3000, 16'sd2000, -16'sd1000, 16'sd16000, 1'b1, 1'b0, 1'b0},
		// invalid pose with recentre: origin returns to identity
		'{16'sd1234, -16'sd4321, 16'sd32767, -16'sd32768, 1'b0, 1'b1, 1'b0},
		'{-16'sd3000, 16'sd2000, -16'sd1000, 16'sd16000, 1'b1, 1'b0, 1'b0},
		'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 1'b1, 1'b1, 1'b0},
		'{16'sd100, 16'sd200, 16'sd300, 16'sd400, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b1, 1'b1, 1'b0},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b1, 1'b1}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [4*Q_W-1:0]  s_tdata;   // raw_x, raw_y, raw_z, raw_w
	logic [1:0]        s_tuser;   // pose_valid, recenter_now
	logic              m_tvalid;
	logic              m_tready;
	logic [PV_W-1:0]   m_tdata;   // pv_c0_r0 .. pv_c0_r3, pv_c1_r0 .. pv_c2_r3

	// predictor state
	logic signed [Q_W-1:0] x_scale_sh, y_scale_sh, depth_scale_sh;
	longint                origin_conj [QN];
	logic [PV_W-1:0]       expected_views [$];

	logic            steady;
	int              failures;
	int              reports;
	int              poses_sent, views_checked, recentres, invalid_poses, scale_sets;
	logic [PV_W-1:0] want_pv;

	head_pose_view_projection i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint neg_clip(input longint v);
		return (-v > 32767) ? 32767 : -v;
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [OUT_W-1:0] clip24(input longint v);
		if (v > 8388607)
			return 24'h7fffff;
		if (v < -8388608)
			return 24'h800000;
		return v[OUT_W-1:0];
	endfunction

	// Remap to EUS, apply any recentre, rotate relative to the origin and project.
	function automatic logic [PV_W-1:0] project_pose(input pose_row_t pz);
		longint          p [QN];
		longint          o [QN];
		longint          r [QN];
		longint          h [3][3];
		longint          sc [3];
		longint          x, y, z, w, one;
		logic [PV_W-1:0] pv;
		if (pz.pose_valid) begin
			p[0] = neg_clip(longint'(pz.raw_y));
			p[1] = longint'(pz.raw_z);
			p[2] = neg_clip(longint'(pz.raw_x));
			p[3] = longint'(pz.raw_w);
		end else begin
			p[0] = 0;
			p[1] = 0;
			p[2] = 0;
			p[3] = 16384;
		end
		if (pz.recentre) begin
			origin_conj[0] = neg_clip(p[0]);
			origin_conj[1] = neg_clip(p[1]);
			origin_conj[2] = neg_clip(p[2]);
			origin_conj[3] = p[3];
		end
		for (int k = 0; k < QN; k++)
			o[k] = origin_conj[k];
		r[0] = round_half_up(o[3]*p[0] + o[0]*p[3] + o[1]*p[2] - o[2]*p[1], REL_SHIFT);
		r[1] = round_half_up(o[3]*p[1] - o[0]*p[2] + o[1]*p[3] + o[2]*p[0], REL_SHIFT);
		r[2] = round_half_up(o[3]*p[2] + o[0]*p[1] - o[1]*p[0] + o[2]*p[3], REL_SHIFT);
		r[3] = round_half_up(o[3]*p[3] - o[0]*p[0] - o[1]*p[1] - o[2]*p[2], REL_SHIFT);
		x = r[0];
		y = r[1];
		z = r[2];
		w = r[3];
		one = longint'(1) <<< 28;
		h[0][0] = one - 2*(y*y + z*z);
		h[0][1] = 2*(x*y - z*w);
		h[0][2] = 2*(x*z + y*w);
		h[1][0] = 2*(x*y + z*w);
		h[1][1] = one - 2*(x*x + z*z);
		h[1][2] = 2*(y*z - x*w);
		h[2][0] = 2*(x*z - y*w);
		h[2][1] = 2*(y*z + x*w);
		h[2][2] = one - 2*(x*x + y*y);
		sc[0] = longint'(x_scale_sh);
		sc[1] = longint'(y_scale_sh);
		sc[2] = longint'(depth_scale_sh);
		for (int c = 0; c < 3; c++) begin
			pv[(c*4 + 0)*OUT_W +: OUT_W] = clip24(round_half_up(sc[0]*h[c][0], SCALED_SHIFT));
			pv[(c*4 + 1)*OUT_W +: OUT_W] = clip24(round_half_up(sc[1]*h[c][1], SCALED_SHIFT));
			pv[(c*4 + 2)*OUT_W +: OUT_W] = clip24(round_half_up(sc[2]*h[c][2], SCALED_SHIFT));
			pv[(c*4 + 3)*OUT_W +: OUT_W] = clip24(round_half_up(-h[c][2], NEG_SHIFT));
		end
		return pv;
	endfunction

	function automatic logic signed [Q_W-1:0] corner_value();
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 16'sd0;
			3: return Q14_ONE;
			4: return -Q14_ONE;
			default: return Q_W'($urandom);
		endcase
	endfunction

	// Mostly unit quaternions, then raw noise and corner values.
	function automatic pose_row_t random_pose();
		pose_row_t pz;
		int        pick, a, b, c, w;
		real       rest;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			a = int'($urandom_range(0, 18000)) - 9000;
			b = int'($urandom_range(0, 18000)) - 9000;
			c = int'($urandom_range(0, 18000)) - 9000;
			rest = 268435456.0 - real'(a)*a - real'(b)*b - real'(c)*c;
			w = int'($sqrt(rest));
			if ($urandom_range(0, 1))
				w = -w;
			pz.raw_x = Q_W'(a);
			pz.raw_y = Q_W'(b);
			pz.raw_z = Q_W'(c);
			pz.raw_w = Q_W'(w);
		end else if (pick < 85) begin
			pz.raw_x = Q_W'($urandom);
			pz.raw_y = Q_W'($urandom);
			pz.raw_z = Q_W'($urandom);
			pz.raw_w = Q_W'($urandom);
		end else begin
			pz.raw_x = corner_value();
			pz.raw_y = corner_value();
			pz.raw_z = corner_value();
			pz.raw_w = corner_value();
		end
		pz.pose_valid = ($urandom_range(0, 9) != 0);
		pz.recentre = ($urandom_range(0, 11) == 0);
		pz.typed = 1'b0;
		return pz;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Call at a falling edge; returns at a falling edge with s_tvalid possibly still high.
	task automatic send_pose(input pose_row_t pz);
		logic [PV_W-1:0] pv;
		int              gap;
		s_tdata = {pz.raw_w, pz.raw_z, pz.raw_y, pz.raw_x};
		s_tuser = {pz.recentre, pz.pose_valid};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pv = project_pose(pz);
		expected_views.insert(expected_views.size(), pz.typed ? IDENTITY_PV : pv);
		poses_sent++;
		if (pz.recentre)
			recentres++;
		if (!pz.pose_valid)
			invalid_poses++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [Q_W-1:0] val);
		logic [15:0] junk;
		junk = 16'($urandom);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {junk, val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_X_SCALE:     x_scale_sh = val;
			REG_Y_SCALE:     y_scale_sh = val;
			REG_DEPTH_SCALE: depth_scale_sh = val;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Hold the input and let every outstanding view drain.
	task automatic drain();
		s_tvalid = 1'b0;
		while (expected_views.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_scales(input int phase);
		case (phase)
			1: begin
				apb_write(REG_X_SCALE, Q_MIN);
				apb_write(REG_Y_SCALE, Q_MIN);
				apb_write(REG_DEPTH_SCALE, Q_MIN);
			end
			2: begin
				apb_write(REG_X_SCALE, Q_MAX);
				apb_write(REG_Y_SCALE, Q_MAX);
				apb_write(REG_DEPTH_SCALE, Q_MAX);
			end
			3: begin
				apb_write(REG_X_SCALE, Q_MAX);
				apb_write(REG_Y_SCALE, Q_MIN);
				apb_write(REG_DEPTH_SCALE, 16'sd0);
			end
			4: begin
				apb_write(REG_X_SCALE, Q_W'($urandom));
				apb_write(REG_UNUSED, Q_W'($urandom));
				apb_write(REG_Y_SCALE, Q_W'($urandom));
				apb_write(REG_DEPTH_SCALE, Q_W'($urandom));
			end
			5: begin
				apb_write(REG_X_SCALE, X_SCALE_RST);
				apb_write(REG_Y_SCALE, Y_SCALE_RST);
				apb_write(REG_DEPTH_SCALE, DEPTH_SCALE_RST);
				apb_write(REG_UNUSED, Q_W'($urandom));
			end
			default: ;
		endcase
		scale_sets++;
	endtask

	// Receiver: mostly ready, with short stalls and the odd long one.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!steady && $urandom_range(0, 7) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
					                                         : $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_views.size() == 0) begin
				failures++;
				if (reports < MAX_REPORTS)
					$display("%0t ns: view with none pending, expected nothing, actual %h",
					         $time, m_tdata);
				reports++;
			end else begin
				want_pv = expected_views.pop_front();
				views_checked++;
				for (int k = 0; k < OUT_N; k++) begin
					if (m_tdata[k*OUT_W +: OUT_W] !== want_pv[k*OUT_W +: OUT_W]) begin
						failures++;
						if (reports < MAX_REPORTS)
							$display("%0t ns: pv_c%0d_r%0d expected %0d actual %0d", $time,
							         k / 4, k % 4, $signed(want_pv[k*OUT_W +: OUT_W]),
							         $signed(m_tdata[k*OUT_W +: OUT_W]));
						reports++;
					end
				end
			end
		end
	end

	initial begin
		#15_000_000;
		$display("head_pose_view_projection: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		steady = 1'b1;
		failures = 0;
		reports = 0;
		poses_sent = 0;
		views_checked = 0;
		recentres = 0;
		invalid_poses = 0;
		scale_sets = 0;
		x_scale_sh = X_SCALE_RST;
		y_scale_sh = Y_SCALE_RST;
		depth_scale_sh = DEPTH_SCALE_RST;
		origin_conj[0] = 0;
		origin_conj[1] = 0;
		origin_conj[2] = 0;
		origin_conj[3] = 16384;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_pose(DIRECTED_POSES[i]);

		// one run of random poses per scale setting, steady traffic in phase 2 and stalled traffic otherwise
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			set_scales(phase);
			steady = (phase == 2);
			repeat (72) send_pose(random_pose());
			steady = 1'b0;
		end

		drain();
		repeat (80) @(negedge clk);
		if (reports > MAX_REPORTS)
			$display("%0d further mismatch reports withheld", reports - MAX_REPORTS);
		$display("checked %0d views from %0d poses (%0d recentres, %0d invalid) over %0d scale sets",
		         views_checked, poses_sent, recentres, invalid_poses, scale_sets);
		if (failures == 0)
			$display("head_pose_view_projection: match");
		else
			$display("head_pose_view_projection: mismatch");
		$finish;
	end

endmodule
